### rtl/core/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer wheel package
// Shared constants, interface structs and helper functions for the timer
// wheel core, its per-timer store and its constant divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

   // Wheel geometry. Ids are 4 bits wide, so at most 16 timers are served.
   localparam int SLOTS      = 10;
   localparam int TIMERS     = 16;
   localparam int ID_W       = 4;
   localparam int KIND_W     = 2;
   localparam int PERIOD_W   = 16;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int ROUND_W    = 13;
   localparam int ROUNDS_MAX = 8191;

   // Scaled reciprocal of SLOTS. The scale leaves an error below one for every
   // dividend of PERIOD_W bits, so the truncated product is the exact quotient.
   localparam int DIV_SHIFT  = PERIOD_W + $clog2(SLOTS);
   localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + SLOTS - 1) / SLOTS;
   localparam int RECIP_W    = PERIOD_W + 2;
   localparam int PROD_W     = PERIOD_W + RECIP_W;

   // Command codes carried by the kind field.
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   // One timer entry as seen on the store's read port.
   typedef struct packed {
      logic               armed;
      logic [SLOT_W-1:0]  slot;
      logic [ROUND_W-1:0] rounds;
      logic [ROUND_W-1:0] reload;
      logic [SLOT_W-1:0]  offs;
   } ptw_entry_type;

   // Write request into the store. Each group of fields has its own enable.
   typedef struct packed {
      logic               wr_armed;
      logic               armed;
      logic               wr_sched;
      logic               wr_reload;
      logic [ID_W-1:0]    addr;
      logic [SLOT_W-1:0]  slot;
      logic [ROUND_W-1:0] rounds;
      logic [ROUND_W-1:0] reload;
      logic [SLOT_W-1:0]  offs;
   } ptw_write_type;

   // Slot that lies offs + 1 slots past cur, modulo SLOTS.
   function automatic logic [SLOT_W-1:0] slot_advance(input logic [SLOT_W-1:0] cur,
                                                      input logic [SLOT_W-1:0] offs);
      logic [SLOT_W:0] sum;
      sum = {1'b0, cur} + {1'b0, offs} + (SLOT_W+1)'(1);
      if (sum >= (SLOT_W+1)'(SLOTS)) begin
         sum = sum - (SLOT_W+1)'(SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

   // Round count clamped to the width of the round field.
   function automatic logic [ROUND_W-1:0] rounds_sat(input logic [PERIOD_W-1:0] q);
      logic [ROUND_W-1:0] r;
      if (q > PERIOD_W'(ROUNDS_MAX)) begin
         r = ROUND_W'(ROUNDS_MAX);
      end else begin
         r = q[ROUND_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ptw_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Division of a 16-bit value by SLOTS through multiplication with a scaled
// reciprocal, in two register stages. Produces quotient and remainder with a
// one-cycle done pulse as the second stage registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ptw_pkg::PERIOD_W-1:0]   dividend,
   output logic                                done,
   output logic [ptw_pkg::PERIOD_W-1:0]        quotient,
   output logic [ptw_pkg::SLOT_W-1:0]          remainder
);
   import ptw_pkg::*;

   logic                  stage_ff, stage_in;
   logic                  done_ff,  done_in;
   logic [PROD_W-1:0]     prod_ff,  prod_in;
   logic [PERIOD_W-1:0]   num_ff,   num_in;
   logic [PERIOD_W-1:0]   quo_ff,   quo_in;
   logic [SLOT_W-1:0]     rem_ff,   rem_in;
   logic [PERIOD_W-1:0]   back;

   // First stage multiplies by the reciprocal; the second takes the quotient
   // from the top of the product and the remainder by multiplying it back.
   always_comb begin
      stage_in = start;
      done_in  = stage_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      back     = '0;
      if (start) begin
         prod_in = {{RECIP_W{1'b0}}, dividend} * PROD_W'(DIV_RECIP);
         num_in  = dividend;
      end
      if (stage_ff) begin
         quo_in = PERIOD_W'(prod_ff >> DIV_SHIFT);
         back   = quo_in * PERIOD_W'(SLOTS);
         rem_in = SLOT_W'(num_ff - back);
      end
   end

   // Control state is reset, the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/core/ptw_store.sv
// ----------------------------------------------------------------------------
// Timer entry store
// Per-timer armed flag, wheel slot, rounds left and the reload values that
// re-arming needs. One read address and one write request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_store (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [ptw_pkg::ID_W-1:0] rd_addr,
   input  wire ptw_pkg::ptw_write_type   wr,
   output ptw_pkg::ptw_entry_type        rd
);
   import ptw_pkg::*;

   logic               armed_ff  [TIMERS];
   logic [SLOT_W-1:0]  slot_ff   [TIMERS];
   logic [ROUND_W-1:0] rounds_ff [TIMERS];
   logic [ROUND_W-1:0] reload_ff [TIMERS];
   logic [SLOT_W-1:0]  offs_ff   [TIMERS];

   // Armed flags are cleared by reset; the payload stays undefined until armed.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMERS; i++) begin
            armed_ff[i] <= 1'b0;
         end
      end else if (wr.wr_armed) begin
         armed_ff[wr.addr] <= wr.armed;
      end
      if (wr.wr_sched) begin
         slot_ff[wr.addr]   <= wr.slot;
         rounds_ff[wr.addr] <= wr.rounds;
      end
      if (wr.wr_reload) begin
         reload_ff[wr.addr] <= wr.reload;
         offs_ff[wr.addr]   <= wr.offs;
      end
   end

   // Read port for the scan and for re-arming.
   always_comb begin
      rd.armed  = armed_ff[rd_addr];
      rd.slot   = slot_ff[rd_addr];
      rd.rounds = rounds_ff[rd_addr];
      rd.reload = reload_ff[rd_addr];
      rd.offs   = offs_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/periodic_timer_wheel_core.sv
// Add: two-stage reciprocal divide by SLOTS, then the entry write.
// Delete clears the armed flag as it is taken; an unused or out-of-range command does nothing.
// Tick: one timer entry scanned per cycle, then a flush step, and a done step when
// a timer expires; scan and flush stall while the result register is not taken.
// One command at a time. Reset clears the current slot, all armed flags and
// the result valid flag.
// ----------------------------------------------------------------------------
// Periodic timer wheel core
// Hashed timing wheel with SLOTS slots. Adds arm a timer, deletes disarm it,
// ticks advance the wheel and report each expiring timer in id order.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_wheel_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ptw_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [ptw_pkg::ID_W-1:0]     req_timer_id,
   input  wire logic [ptw_pkg::PERIOD_W-1:0] req_period,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [ptw_pkg::ID_W-1:0]          rsp_expired_id,
   output logic                              rsp_last
);
   import ptw_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  cur_ff,   cur_in;
   logic [ID_W-1:0]    idx_ff,   idx_in;
   logic               hold_vld_ff, hold_vld_in;
   logic [ID_W-1:0]    hold_id_ff,  hold_id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff,    rsp_id_in;
   logic               rsp_last_ff,  rsp_last_in;

   logic                div_start;
   logic [PERIOD_W-1:0] div_dividend;
   logic                div_done;
   logic [PERIOD_W-1:0] div_quot;
   logic [SLOT_W-1:0]   div_rem;

   logic [ID_W-1:0]     rd_addr;
   ptw_entry_type       entry;
   ptw_write_type       wr;

   logic                accept;
   logic                id_ok;
   logic                out_free;
   logic                hit;
   logic [ROUND_W-1:0]  new_rounds;

   ptw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   ptw_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd      (entry)
   );

   assign accept   = req_valid && req_ready;
   assign id_ok    = {1'b0, req_timer_id} < (ID_W+1)'(TIMERS);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_addr  = idx_ff;
   assign hit      = entry.armed && (entry.slot == cur_ff);
   assign new_rounds = rounds_sat(div_quot);

   // Divider operand is period - 1, with a period of zero taken as one.
   assign div_start    = accept && (req_kind == KIND_ADD) && id_ok;
   assign div_dividend = (req_period == '0) ? '0 : req_period - PERIOD_W'(1);

   // Sequencer: command decode, arming and the tick scan.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      hold_vld_in  = hold_vld_ff;
      hold_id_in   = hold_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      wr           = '0;
      wr.addr      = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = req_timer_id;
               priority if (req_kind == KIND_TICK) begin
                  if (cur_ff == SLOT_W'(SLOTS - 1)) begin
                     cur_in = '0;
                  end else begin
                     cur_in = cur_ff + SLOT_W'(1);
                  end
                  idx_in      = '0;
                  hold_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end else if (req_kind == KIND_ADD && id_ok) begin
                  state_in = ST_DIV;
               end else if (req_kind == KIND_DELETE && id_ok) begin
                  wr.wr_armed = 1'b1;
                  wr.armed    = 1'b0;
                  wr.addr     = req_timer_id;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Wait for the divide, then place the timer relative to the current slot.
         ST_DIV: begin
            if (div_done) begin
               wr.wr_armed  = 1'b1;
               wr.armed     = 1'b1;
               wr.wr_sched  = 1'b1;
               wr.wr_reload = 1'b1;
               wr.slot      = slot_advance(cur_ff, div_rem);
               wr.rounds    = new_rounds;
               wr.reload    = new_rounds;
               wr.offs      = div_rem;
               state_in     = ST_IDLE;
            end
         end

         // One entry per cycle unless an expiry waits on the result register. A firing
         // timer is held back until the next expiry or the flush so that the final word of the tick can carry last.
         ST_SCAN: begin
            if (hit && entry.rounds == '0) begin
               if (!hold_vld_ff || out_free) begin
                  if (hold_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = hold_id_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_vld_in = 1'b1;
                  hold_id_in  = idx_ff;
                  wr.wr_sched = 1'b1;
                  wr.slot     = slot_advance(cur_ff, entry.offs);
                  wr.rounds   = entry.reload;
                  idx_in      = idx_ff + ID_W'(1);
                  if (idx_ff == ID_W'(TIMERS - 1)) begin
                     state_in = ST_FLUSH;
                  end
               end
            end else begin
               if (hit) begin
                  wr.wr_sched = 1'b1;
                  wr.slot     = entry.slot;
                  wr.rounds   = entry.rounds - ROUND_W'(1);
               end
               idx_in = idx_ff + ID_W'(1);
               if (idx_ff == ID_W'(TIMERS - 1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         // Emit the held expiry, if any, as the last word of the tick.
         ST_FLUSH: begin
            if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = hold_id_ff;
               rsp_last_in  = 1'b1;
               hold_vld_in  = 1'b0;
               state_in     = ST_DONE;
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers take reset; held ids and result payload do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      hold_id_ff  <= hold_id_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
